// ----- src/stq_pkg.sv -----
// Package for the sorted timer queue: request modes, status codes and cell commands.
// Depends on nothing; imported by stq_cell and sorted_timer_queue_unit.
package stq_pkg;

  localparam int ID_WIDTH    = 4;
  localparam int ID_COUNT    = 16;
  localparam int MAX_REPORTS = 16;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_ADJUST = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_ABSENT  = 2'd2,
    STATUS_PRESENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_EXEC     = 2'd1,
    ST_REINSERT = 2'd2
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t              op;
    logic [ID_WIDTH-1:0]   key_id;
  } cell_cmd_t;

endpackage

// ----- src/stq_cell.sv -----
// One slot of the sorted chain: holds an expiry time and an owner id.
// Depends on stq_pkg; instantiated DEPTH times by sorted_timer_queue_unit.
module stq_cell import stq_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_cmd_t             cmd,
  input  logic [TIME_WIDTH-1:0] key_time,
  input  logic                  left_used,
  input  logic [TIME_WIDTH-1:0] left_expiry,
  input  logic [ID_WIDTH-1:0]   left_owner,
  input  logic                  left_keep,
  input  logic                  right_used,
  input  logic [TIME_WIDTH-1:0] right_expiry,
  input  logic [ID_WIDTH-1:0]   right_owner,
  input  logic                  found_in,
  output logic                  used,
  output logic [TIME_WIDTH-1:0] expiry,
  output logic [ID_WIDTH-1:0]   owner,
  output logic                  keep,
  output logic                  found_out
);

  logic hit;

  // The entry stays put on an insert when it is not later than the key.
  assign keep      = used && (expiry <= key_time);
  assign hit       = found_in || (used && (owner == cmd.key_id));
  assign found_out = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else begin
      unique case (cmd.op)
        CELL_INSERT: begin
          if (!keep) begin
            used <= left_keep ? 1'b1 : left_used;
          end
        end
        CELL_REMOVE: begin
          if (hit) begin
            used <= right_used;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CELL_INSERT: begin
        if (!keep) begin
          expiry <= left_keep ? key_time : left_expiry;
          owner  <= left_keep ? cmd.key_id : left_owner;
        end
      end
      CELL_REMOVE: begin
        if (hit) begin
          expiry <= right_expiry;
          owner  <= right_owner;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/sorted_timer_queue_unit.sv -----
// Top level of the sorted timer queue: request control, id table and the chain of slots.
// Depends on stq_pkg and stq_cell.
//
//   channel | direction | tdata (low bit up)                        | tuser       | tlast
//   s_      | in        | timer_id, expire_time, user_tag, cur_time | mode        | -
//   m_      | out       | status, expired_valid, out_timer_id, tag  | report_kind | last
//
// An item is taken in the idle state and worked in the exec state, where add and delete
// finish; adjust then runs a reinsert state (remove pass, then insert pass through the
// chain), and a tick emits one expiry report per due head, up to MAX_REPORTS. All
// cells update at once, a moving cell taking the key or its left or right neighbour.
// Reset (synchronous, active high) empties the chain, the id table and the count.
// A stalled output holds the pending item; work that must emit waits for it.
module sorted_timer_queue_unit import stq_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int TIME_WIDTH = 32,
  parameter int TAG_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // timer_id [3:0], expire_time [35:4], user_tag [51:36], current_time [83:52]
  input  logic [87:0] s_tdata,
  // mode [1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status [1:0], expired_valid [2], out_timer_id [6:3], out_user_tag [22:7]
  output logic [23:0] m_tdata,
  // report_kind [0]
  output logic [0:0]  m_tuser,
  output logic        m_tlast
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int TW = TIME_WIDTH;
  localparam int RW = $clog2(MAX_REPORTS);

  // Captured request.
  mode_t                 req_mode;
  logic [ID_WIDTH-1:0]   req_id;
  logic [TW-1:0]         req_exp;
  logic [TAG_WIDTH-1:0]  req_tag;
  logic [TW-1:0]         req_now;

  logic [TW+31:0]        exp_ext;
  logic [TW+31:0]        now_ext;
  logic [TAG_WIDTH+15:0] tag_in_ext;

  state_t                state;
  state_t                state_next;
  logic [CW-1:0]         entry_count;
  logic [ID_COUNT-1:0]   id_active;
  logic [TAG_WIDTH-1:0]  tag_store [ID_COUNT];
  logic [RW-1:0]         tick_count;

  // Chain wiring.
  cell_cmd_t             cmd;
  logic [TW-1:0]         key_time;
  logic                  pop;
  logic                  cell_used   [DEPTH];
  logic [TW-1:0]         cell_expiry [DEPTH];
  logic [ID_WIDTH-1:0]   cell_owner  [DEPTH];
  logic                  cell_keep   [DEPTH];
  logic                  cell_found  [DEPTH];

  // Control decisions of this cycle.
  logic                  ofree;
  logic                  emit;
  logic                  o_kind;
  status_t               o_status;
  logic                  o_valid;
  logic [ID_WIDTH-1:0]   o_id;
  logic [15:0]           o_tag;
  logic                  o_last;
  logic                  set_active;
  logic                  clr_active;
  logic [ID_WIDTH-1:0]   clr_id;
  logic                  write_tag;
  logic                  cnt_inc;
  logic                  cnt_dec;
  logic                  tick_inc;
  logic [TAG_WIDTH+15:0] tag_out_ext;

  // No item is taken while reset is held.
  assign s_tready = (state == ST_IDLE) && !rst;
  assign ofree    = !m_tvalid || m_tready;

  // Input fields are fitted to the configured widths (zero extension or truncation).
  assign exp_ext    = {{TW{1'b0}}, s_tdata[35:4]};
  assign now_ext    = {{TW{1'b0}}, s_tdata[83:52]};
  assign tag_in_ext = {{TAG_WIDTH{1'b0}}, s_tdata[51:36]};

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_mode <= mode_t'(s_tuser);
      req_id   <= s_tdata[3:0];
      req_exp  <= exp_ext[TW-1:0];
      req_tag  <= tag_in_ext[TAG_WIDTH-1:0];
      req_now  <= now_ext[TW-1:0];
    end
  end

  // A tick compares the chain against the present time, the other requests
  // against the new expiry time.
  assign key_time = (req_mode == MODE_TICK) ? req_now : req_exp;

  // The chain of slots. Cell 0 sees a virtual left neighbour that always keeps,
  // so an insert in front of everything lands there; the last cell sees an
  // empty right neighbour. A pop marks cell 0 as the removed slot.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                left_used;
    logic [TW-1:0]       left_expiry;
    logic [ID_WIDTH-1:0] left_owner;
    logic                left_keep;
    logic                right_used;
    logic [TW-1:0]       right_expiry;
    logic [ID_WIDTH-1:0] right_owner;
    logic                found_in;

    if (i == 0) begin : g_head
      assign left_used   = 1'b0;
      assign left_expiry = '0;
      assign left_owner  = '0;
      assign left_keep   = 1'b1;
      assign found_in    = pop;
    end else begin : g_body
      assign left_used   = cell_used[i-1];
      assign left_expiry = cell_expiry[i-1];
      assign left_owner  = cell_owner[i-1];
      assign left_keep   = cell_keep[i-1];
      assign found_in    = cell_found[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_used   = 1'b0;
      assign right_expiry = '0;
      assign right_owner  = '0;
    end else begin : g_inner
      assign right_used   = cell_used[i+1];
      assign right_expiry = cell_expiry[i+1];
      assign right_owner  = cell_owner[i+1];
    end

    stq_cell #(
      .TIME_WIDTH (TW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .key_time     (key_time),
      .left_used    (left_used),
      .left_expiry  (left_expiry),
      .left_owner   (left_owner),
      .left_keep    (left_keep),
      .right_used   (right_used),
      .right_expiry (right_expiry),
      .right_owner  (right_owner),
      .found_in     (found_in),
      .used         (cell_used[i]),
      .expiry       (cell_expiry[i]),
      .owner        (cell_owner[i]),
      .keep         (cell_keep[i]),
      .found_out    (cell_found[i])
    );
  end

  assign tag_out_ext = {16'b0, tag_store[cell_owner[0]]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = CELL_HOLD;
    cmd.key_id = req_id;
    pop        = 1'b0;
    emit       = 1'b0;
    o_kind     = 1'b0;
    o_status   = STATUS_OK;
    o_valid    = 1'b0;
    o_id       = req_id;
    o_tag      = '0;
    o_last     = 1'b1;
    set_active = 1'b0;
    clr_active = 1'b0;
    clr_id     = req_id;
    write_tag  = 1'b0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    tick_inc   = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (req_mode)
          MODE_ADD: begin
            if (ofree) begin
              emit       = 1'b1;
              state_next = ST_IDLE;
              if (id_active[req_id]) begin
                o_status = STATUS_PRESENT;
              end else if (entry_count == CW'(DEPTH)) begin
                o_status = STATUS_FULL;
              end else begin
                cmd.op     = CELL_INSERT;
                set_active = 1'b1;
                write_tag  = 1'b1;
                cnt_inc    = 1'b1;
              end
            end
          end
          MODE_ADJUST: begin
            // The timer is first taken out, then put back in the reinsert state.
            if (!id_active[req_id]) begin
              if (ofree) begin
                emit       = 1'b1;
                o_status   = STATUS_ABSENT;
                state_next = ST_IDLE;
              end
            end else begin
              cmd.op     = CELL_REMOVE;
              state_next = ST_REINSERT;
            end
          end
          MODE_DELETE: begin
            if (ofree) begin
              emit       = 1'b1;
              state_next = ST_IDLE;
              if (!id_active[req_id]) begin
                o_status = STATUS_ABSENT;
              end else begin
                cmd.op     = CELL_REMOVE;
                clr_active = 1'b1;
                cnt_dec    = 1'b1;
              end
            end
          end
          MODE_TICK: begin
            if (ofree) begin
              emit   = 1'b1;
              o_kind = 1'b1;
              if (cell_keep[0]) begin
                // The head is due: report it and shift the chain left by one.
                cmd.op     = CELL_REMOVE;
                pop        = 1'b1;
                o_valid    = 1'b1;
                o_id       = cell_owner[0];
                o_tag      = tag_out_ext[15:0];
                clr_active = 1'b1;
                clr_id     = cell_owner[0];
                cnt_dec    = 1'b1;
                tick_inc   = 1'b1;
                o_last     = !cell_keep[1] || (tick_count == RW'(MAX_REPORTS - 1));
                if (o_last) begin
                  state_next = ST_IDLE;
                end
              end else begin
                // Nothing due on the first look: one empty report.
                o_id       = '0;
                state_next = ST_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_REINSERT: begin
        if (ofree) begin
          cmd.op     = CELL_INSERT;
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      id_active   <= '0;
      tick_count  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cnt_inc) begin
        entry_count <= entry_count + CW'(1);
      end else if (cnt_dec) begin
        entry_count <= entry_count - CW'(1);
      end
      if (set_active) begin
        id_active[req_id] <= 1'b1;
      end else if (clr_active) begin
        id_active[clr_id] <= 1'b0;
      end
      if (s_tvalid && s_tready) begin
        tick_count <= '0;
      end else if (tick_inc) begin
        tick_count <= tick_count + RW'(1);
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_tag) begin
      tag_store[req_id] <= req_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {1'b0, o_tag, o_id, o_valid, o_status};
      m_tuser <= o_kind;
      m_tlast <= o_last;
    end
  end

endmodule
